@@ sv/lpr_pkg.sv @@
// Shared types and constants for the LRU page replacement block.
// No dependencies; every other file of the block refers to this package.
package lpr_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;
  localparam int AGE_BITS  = 16;
  localparam int FAULT_BITS = 16;
  localparam int IDX_W     = $clog2(FRAMES);
  localparam int CFG_W     = 4;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = CFG_W'(4);

  // Register index decoded from the word address.
  typedef enum logic [0:0] {
    REG_FRAMES_IN_USE = 1'b0,
    REG_UNMAPPED      = 1'b1
  } lpr_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } lpr_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } lpr_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } lpr_status_t;

endpackage

@@ sv/lpr_access_if.sv @@
// Access channel: one page number per beat.
// Depends on lpr_pkg for the page width.
interface lpr_access_if;
  logic                          valid;
  logic                          ready;
  logic [lpr_pkg::PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

@@ sv/lpr_result_if.sv @@
// Result channel: one lookup outcome per beat.
// Depends on lpr_pkg for field widths.
interface lpr_result_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [lpr_pkg::IDX_W-1:0]      frame_index;
  logic                           evicted_valid;
  logic [lpr_pkg::PAGE_BITS-1:0]  evicted_page;
  logic [lpr_pkg::FAULT_BITS-1:0] fault_total;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_total, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input fault_total, output ready);
endinterface

@@ sv/lpr_ctrl.sv @@
// Sequencer for one access: accept, scan active frames, commit.
// Depends on lpr_pkg for state, command and status types.
module lpr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                access_valid,
  output logic                access_ready,
  input  lpr_pkg::lpr_status_t status,
  output lpr_pkg::lpr_cmd_t    cmd
);

  lpr_pkg::lpr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    access_ready = 1'b0;
    unique case (state)
      lpr_pkg::ST_IDLE: begin
        access_ready = 1'b1;
        if (access_valid) begin
          cmd.load   = 1'b1;
          state_next = lpr_pkg::ST_SCAN;
        end
      end
      lpr_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = lpr_pkg::ST_COMMIT;
        end
      end
      lpr_pkg::ST_COMMIT: begin
        // hold until the result register can take the beat
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = lpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lpr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/lpr_dp.sv @@
// Frame table, age scan, victim choice and result register.
// Depends on lpr_pkg and lpr_result_if.
module lpr_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lpr_pkg::CFG_W-1:0]     frames_in_use,
  input  logic [lpr_pkg::PAGE_BITS-1:0] page_number,
  input  lpr_pkg::lpr_cmd_t             cmd,
  output lpr_pkg::lpr_status_t          status,
  lpr_result_if.source                  result
);

  localparam int IW = lpr_pkg::IDX_W;
  localparam int PW = lpr_pkg::PAGE_BITS;
  localparam int AW = lpr_pkg::AGE_BITS;
  localparam int FW = lpr_pkg::FAULT_BITS;
  localparam int CW = lpr_pkg::CFG_W;

  logic [PW-1:0] frame_page  [lpr_pkg::FRAMES];
  logic          frame_valid [lpr_pkg::FRAMES];
  logic [AW-1:0] frame_age   [lpr_pkg::FRAMES];
  logic [FW-1:0] fault_count;

  logic [PW-1:0] page_q;
  logic [IW-1:0] idx;
  logic [IW-1:0] victim;
  logic [AW-1:0] best;
  logic          hit_found;
  logic [IW-1:0] hit_idx;

  logic          out_valid;
  logic          out_hit;
  logic [IW-1:0] out_frame;
  logic          out_ev_valid;
  logic [PW-1:0] out_ev_page;
  logic [FW-1:0] out_fault;

  logic [CW-1:0] n_eff;
  logic [IW-1:0] last_idx;
  logic [IW-1:0] sel;
  logic [IW-1:0] rd_addr;
  logic [PW-1:0] rd_page;
  logic          rd_valid;
  logic [AW-1:0] rd_age;
  logic [AW-1:0] aged;
  logic          age_we;
  logic [IW-1:0] age_wa;
  logic [AW-1:0] age_wd;
  logic          miss_commit;
  logic [FW-1:0] fault_next;

  // clamp the active count to 1..FRAMES
  always_comb begin
    priority if (frames_in_use == '0) begin
      n_eff = CW'(1);
    end else if (frames_in_use > CW'(lpr_pkg::FRAMES)) begin
      n_eff = CW'(lpr_pkg::FRAMES);
    end else begin
      n_eff = frames_in_use;
    end
  end

  assign last_idx = IW'(n_eff - CW'(1));
  assign sel      = hit_found ? hit_idx : victim;
  assign rd_addr  = cmd.commit ? sel : idx;
  assign rd_page  = frame_page[rd_addr];
  assign rd_valid = frame_valid[rd_addr];
  assign rd_age   = frame_age[rd_addr];
  assign aged     = (rd_age == '1) ? rd_age : rd_age + AW'(1);

  assign miss_commit = cmd.commit && !hit_found;
  assign fault_next  = (fault_count == '1) ? fault_count : fault_count + FW'(1);

  assign age_we = cmd.scan || cmd.commit;
  assign age_wa = cmd.scan ? idx : sel;
  assign age_wd = cmd.scan ? aged : '0;

  assign status.scan_last = (idx == last_idx);
  assign status.out_free  = !out_valid || result.ready;

  // scan bookkeeping: one frame per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_q    <= page_number;
      idx       <= '0;
      victim    <= '0;
      best      <= '0;
      hit_found <= 1'b0;
      hit_idx   <= '0;
    end else if (cmd.scan) begin
      idx <= idx + IW'(1);
      if (!hit_found && rd_valid && rd_page == page_q) begin
        hit_found <= 1'b1;
        hit_idx   <= idx;
      end
      if (aged > best) begin
        best   <= aged;
        victim <= idx;
      end
    end
  end

  // valid bits and ages clear on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
        frame_valid[i] <= 1'b0;
        frame_age[i]   <= '0;
      end
      fault_count <= '0;
    end else begin
      if (age_we) begin
        frame_age[age_wa] <= age_wd;
      end
      if (miss_commit) begin
        frame_valid[victim] <= 1'b1;
        fault_count         <= fault_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (miss_commit) begin
      frame_page[victim] <= page_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit      <= hit_found;
      out_frame    <= sel;
      out_ev_valid <= !hit_found && rd_valid;
      out_ev_page  <= (!hit_found && rd_valid) ? rd_page : '0;
      out_fault    <= hit_found ? fault_count : fault_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.hit           = out_hit;
  assign result.frame_index   = out_frame;
  assign result.evicted_valid = out_ev_valid;
  assign result.evicted_page  = out_ev_page;
  assign result.fault_total   = out_fault;

endmodule

@@ sv/lru_page_replacement.sv @@
// Top level of the LRU page replacement block: APB register and glue.
// Depends on lpr_pkg, lpr_access_if, lpr_result_if, lpr_ctrl and lpr_dp.
//
// Usage:
//   access: valid/ready channel, one page number per beat.
//   result: valid/ready channel, one beat per access: hit flag, frame index,
//           evicted page (with its valid flag) and the running fault count.
//   APB port: one register, frames_in_use at byte address 0 (4 bits, reset 4).
//           A value of 0 acts as 1, above 8 acts as 8; the written bits are
//           kept and read back. Write it only while the block is idle.
// Sequence: the block takes the beat, then the age scan visits the N active
//   frames one at a time (the frame table has a single read port), then a
//   commit updates the frame and loads the result register. A new access is
//   taken only after the commit, and the result is valid on the cycle after
//   commit.
// Stalls: the result register holds its beat until taken; the next access is
//   accepted meanwhile, and its commit waits while the register is still full.
// Reset (rst, synchronous): clears all valid bits, ages and the fault count,
//   restores frames_in_use to 4 and empties the result register.
module lru_page_replacement (
  input  logic                         clk,
  input  logic                         rst,
  lpr_access_if.sink                   access,
  lpr_result_if.source                 result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lpr_pkg::ADDR_W-1:0]   paddr,
  input  logic [lpr_pkg::DATA_W-1:0]   pwdata,
  output logic [lpr_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic [lpr_pkg::CFG_W-1:0] frames_in_use;
  lpr_pkg::lpr_reg_t         reg_sel;
  lpr_pkg::lpr_cmd_t         cmd;
  lpr_pkg::lpr_status_t      status;
  logic                      cfg_write;

  assign pready = 1'b1;

  // word address picks the register; anything past index 0 is unmapped
  assign reg_sel   = lpr_pkg::lpr_reg_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lpr_pkg::FRAMES_IN_USE_RESET;
    end else if (cfg_write && reg_sel == lpr_pkg::REG_FRAMES_IN_USE) begin
      frames_in_use <= pwdata[lpr_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      lpr_pkg::REG_FRAMES_IN_USE: prdata = lpr_pkg::DATA_W'(frames_in_use);
      default:                    prdata = '0;
    endcase
  end

  lpr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .access_valid (access.valid),
    .access_ready (access.ready),
    .status       (status),
    .cmd          (cmd)
  );

  lpr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .frames_in_use (frames_in_use),
    .page_number   (access.page_number),
    .cmd           (cmd),
    .status        (status),
    .result        (result)
  );

endmodule
